// ===== rtl/core/civil_datetime_to_epoch_ms_macros.svh =====
// Assertion macros shared by the date and time to epoch conversion block.
`ifndef CIVIL_DATETIME_TO_EPOCH_MS_MACROS_SVH
`define CIVIL_DATETIME_TO_EPOCH_MS_MACROS_SVH

// Same-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define CDTE_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and quiet while i_rst_n is low.
`define CDTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cdte_pkg.sv =====
// Shared widths, constants, tables and types for the date and time to epoch conversion.
package cdte_pkg;

    // Field widths.
    localparam int YEAR_W  = 14;
    localparam int FIELD_W = 7;
    localparam int EPOCH_W = 49;
    localparam int DAYS_W  = 23;
    localparam int SOD_W   = 19;
    localparam int SECS_W  = 40;
    localparam int PROD_W  = 26;

    // Calendar and clock limits.
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [FIELD_W-1:0] MONTH_MAX  = 7'd12;
    localparam logic [FIELD_W-1:0] HOUR_MAX   = 7'd23;
    localparam logic [FIELD_W-1:0] MINUTE_MAX = 7'd59;
    localparam logic [FIELD_W-1:0] SECOND_MAX = 7'd60;
    localparam logic [FIELD_W-1:0] FEB        = 7'd2;

    // Years are biased by one era so the day count stays unsigned until the end.
    localparam logic [14:0] YEAR_BIAS = 15'd400;

    // Floor division by 25 as a multiply by 5243 and a shift by 17.
    localparam logic [12:0] RECIP_25    = 13'd5243;
    localparam int          RECIP_SHIFT = 17;

    // Epoch offset of the day count: 719468 plus one era (146097) plus one
    // for the day of month counting from 1.
    localparam logic signed [24:0] DAY_OFFSET = 25'sd865566;

    // Seconds per unit.
    localparam logic [SOD_W-1:0]         SECS_PER_HOUR = 19'd3600;
    localparam logic [SOD_W-1:0]         SECS_PER_MIN  = 19'd60;
    localparam logic signed [SECS_W-1:0] SECS_PER_DAY  = 40'sd86400;

    // Range of a valid result.
    localparam logic signed [EPOCH_W-1:0] EPOCH_MIN_MS = -49'sd62167219200000;
    localparam logic signed [EPOCH_W-1:0] EPOCH_MAX_MS = 49'sd253402300800000;

    // Result of the calendar stage.
    typedef struct packed {
        logic                     ok;
        logic signed [DAYS_W-1:0] days;
    } t_date_res;

    // Length of a month in a common year.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days from the first of March to the first of the month (March-based year).
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] doy;
        unique case (m)
            4'd3:    doy = 9'd0;
            4'd4:    doy = 9'd31;
            4'd5:    doy = 9'd61;
            4'd6:    doy = 9'd92;
            4'd7:    doy = 9'd122;
            4'd8:    doy = 9'd153;
            4'd9:    doy = 9'd184;
            4'd10:   doy = 9'd214;
            4'd11:   doy = 9'd245;
            4'd12:   doy = 9'd275;
            4'd1:    doy = 9'd306;
            4'd2:    doy = 9'd337;
            default: doy = 9'd0;
        endcase
        return doy;
    endfunction

endpackage

// ===== rtl/core/cdte_days.sv =====
// Two-stage calendar check and day count since the Unix epoch.
module cdte_days (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [cdte_pkg::YEAR_W-1:0]     i_year,
    input  logic [cdte_pkg::FIELD_W-1:0]    i_month,
    input  logic [cdte_pkg::FIELD_W-1:0]    i_day,
    output cdte_pkg::t_date_res             o_res
);
    import cdte_pkg::*;

    // Stage A registers.
    logic [PROD_W-1:0]  r_yr_prod_a;
    logic [PROD_W-1:0]  r_y_prod_a;
    logic [YEAR_W-1:0]  r_year_a;
    logic [14:0]        r_y_a;
    logic [FIELD_W-1:0] r_day_a;
    logic [4:0]         r_mlen_a;
    logic [8:0]         r_doy_a;
    logic               r_feb_a;
    logic               r_mon_ok_a;
    logic               r_year_ok_a;

    // Stage A next values.
    logic               n_early;
    logic [14:0]        n_y;
    logic               n_mon_ok;
    logic [3:0]         n_mon_idx;

    // Stage B logic.
    logic [7:0]         yq;
    logic               cent;
    logic               leap;
    logic [4:0]         lim;
    logic               date_ok;
    logic [8:0]         yc;
    logic [23:0]        sum_u;
    logic signed [24:0] days_w;
    t_date_res          r_res;

    // Stage A: shift the year to start in March and start both divisions by 100.
    always_comb begin
        n_early   = (i_month <= FEB);
        n_y       = 15'(i_year) + YEAR_BIAS - 15'(n_early);
        n_mon_ok  = (i_month != '0) && (i_month <= MONTH_MAX);
        n_mon_idx = n_mon_ok ? i_month[3:0] : 4'd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_yr_prod_a <= PROD_W'(i_year[YEAR_W-1:2]) * PROD_W'(RECIP_25);
            r_y_prod_a  <= PROD_W'(n_y[14:2]) * PROD_W'(RECIP_25);
            r_year_a    <= i_year;
            r_y_a       <= n_y;
            r_day_a     <= i_day;
            r_mlen_a    <= month_len(n_mon_idx);
            r_doy_a     <= month_start(n_mon_idx);
            r_feb_a     <= (i_month == FEB);
            r_mon_ok_a  <= n_mon_ok;
            r_year_ok_a <= (i_year <= YEAR_MAX);
        end
    end

    // Stage B: leap rule, day range check and the day count.
    always_comb begin
        yq      = r_yr_prod_a[RECIP_SHIFT+7:RECIP_SHIFT];
        cent    = (r_year_a == (YEAR_W'(yq) * 14'd100));
        leap    = ((r_year_a[1:0] == 2'd0) && !cent) || (cent && (yq[1:0] == 2'd0));
        lim     = (r_feb_a && leap) ? 5'd29 : r_mlen_a;
        date_ok = r_year_ok_a && r_mon_ok_a && (r_day_a != '0)
                  && (r_day_a <= FIELD_W'(lim));
        yc      = r_y_prod_a[RECIP_SHIFT+8:RECIP_SHIFT];
        sum_u   = 24'(r_y_a) * 24'd365 + 24'(r_y_a[14:2]) + 24'(yc[8:2])
                  + 24'(r_doy_a) + 24'(r_day_a) - 24'(yc);
        days_w  = $signed({1'b0, sum_u}) - DAY_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res.ok   <= date_ok;
            r_res.days <= days_w[DAYS_W-1:0];
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/core/civil_datetime_to_epoch_ms.sv =====
// Top level: checks a parsed date and time and converts it to Unix epoch milliseconds.
//
// Input channel: i_valid with the six fields i_year .. i_second; an item is taken
// at a clock edge where i_valid is high and o_stall is low.
// Output channel: o_valid with o_valid_res and o_epoch_ms; the item is taken at a
// clock edge where o_valid is high and i_stall is low.
// Each input item gives exactly one result item. o_valid_res is 1 when the date
// and clock fields all pass their checks; otherwise o_epoch_ms is zero.
// The accepting edge loads calendar stage A; the item then moves on through day
// count stage B, seconds multiply stage C and the millisecond output register D,
// which drives o_valid. Throughput is one item per cycle while the receiver
// does not stall; the four stages move together.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// o_stall rises in the same cycle, so no item is lost or repeated. Bubbles move
// forward while the output is free.
// A synchronous active-low reset clears the stage valid bits; the pipeline is
// then empty and ready in the next cycle.
`include "civil_datetime_to_epoch_ms_macros.svh"

module civil_datetime_to_epoch_ms (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [cdte_pkg::YEAR_W-1:0]          i_year,
    input  logic [cdte_pkg::FIELD_W-1:0]         i_month,
    input  logic [cdte_pkg::FIELD_W-1:0]         i_day,
    input  logic [cdte_pkg::FIELD_W-1:0]         i_hour,
    input  logic [cdte_pkg::FIELD_W-1:0]         i_minute,
    input  logic [cdte_pkg::FIELD_W-1:0]         i_second,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_valid_res,
    output logic signed [cdte_pkg::EPOCH_W-1:0]  o_epoch_ms
);
    import cdte_pkg::*;

    logic                      en;
    logic                      r_vld_a, r_vld_b, r_vld_c, r_vld_d;
    logic                      r_hms_ok_a, r_hms_ok_b;
    logic [SOD_W-1:0]          r_sod_a, r_sod_b;
    logic                      r_ok_c, r_ok_d;
    logic signed [SECS_W-1:0]  r_secs_c;
    logic signed [EPOCH_W-1:0] r_epoch_d;
    t_date_res                 date_res;
    logic [SOD_W-1:0]          n_sod;
    logic signed [SECS_W-1:0]  n_secs;
    logic signed [EPOCH_W:0]   ms_ext;
    logic signed [EPOCH_W:0]   n_ms;

    // The pipeline advances unless a finished item waits on a stalled receiver.
    assign en      = !(r_vld_d && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld_d;

    // Valid bits travel with the items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else if (en) begin
            r_vld_a <= i_valid;
            r_vld_b <= r_vld_a;
            r_vld_c <= r_vld_b;
            r_vld_d <= r_vld_c;
        end
    end

    // Calendar check and day count over stages A and B.
    cdte_days u_days (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_year  (i_year),
        .i_month (i_month),
        .i_day   (i_day),
        .o_res   (date_res)
    );

    // Stages A and B: clock field checks and the seconds of the day.
    assign n_sod = SOD_W'(i_hour) * SECS_PER_HOUR + SOD_W'(i_minute) * SECS_PER_MIN
                   + SOD_W'(i_second);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hms_ok_a <= (i_hour <= HOUR_MAX) && (i_minute <= MINUTE_MAX)
                          && (i_second <= SECOND_MAX);
            r_sod_a    <= n_sod;
            r_hms_ok_b <= r_hms_ok_a;
            r_sod_b    <= r_sod_a;
        end
    end

    // Stage C: seconds since the epoch.
    assign n_secs = SECS_W'(date_res.days) * SECS_PER_DAY + $signed({21'd0, r_sod_b});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok_c   <= date_res.ok && r_hms_ok_b;
            r_secs_c <= n_secs;
        end
    end

    // Stage D: times 1000 as 1024 - 16 - 8, zero when a check failed.
    assign ms_ext = (EPOCH_W+1)'(r_secs_c);
    assign n_ms   = (ms_ext <<< 10) - (ms_ext <<< 4) - (ms_ext <<< 3);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ok_d    <= r_ok_c;
            r_epoch_d <= r_ok_c ? n_ms[EPOCH_W-1:0] : '0;
        end
    end

    assign o_valid_res = r_ok_d;
    assign o_epoch_ms  = r_epoch_d;

    // Checks on the pipeline and its results.
    `CDTE_ASSERT(a_bad_gives_zero, o_valid && !o_valid_res, o_epoch_ms == '0, "failed item has nonzero epoch_ms")
    `CDTE_ASSERT(a_good_in_range, o_valid && o_valid_res, (o_epoch_ms >= EPOCH_MIN_MS) && (o_epoch_ms <= EPOCH_MAX_MS), "valid epoch_ms out of range")
    `CDTE_ASSERT(a_stall_backs_up, o_valid && i_stall, o_stall, "stalled output did not hold the pipeline")
    `CDTE_ASSERT_NEXT(a_accept_enters, i_valid && !o_stall, r_vld_a, "accepted item did not enter stage A")
    `CDTE_ASSERT_NEXT(a_hold_freezes, o_stall, $stable(r_vld_c) && $stable(r_ok_c) && $stable(r_secs_c), "stage C moved during a stall")

endmodule
